// File: rtl/core/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants of the integer matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package imm_pkg;

  // Default largest matrix dimension
  localparam int unsigned MAX_DIM_DEF = 8;

  // Element and register widths
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register map, one word each
  typedef enum logic [1:0] {
    REG_ROWS_A = 2'd0,
    REG_COLS_A = 2'd1,
    REG_ROWS_B = 2'd2,
    REG_COLS_B = 2'd3
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_WAIT  = 2'd2,
    ST_ERR   = 2'd3
  } ctrl_state_e;

  // Commands from sequencer to datapath
  typedef struct packed {
    logic wr_a;     // write element into store A
    logic wr_b;     // write element into store B
    logic rd;       // read one A/B pair for the inner sum
    logic first;    // pair opens a new sum
    logic lastk;    // pair closes the sum
    logic emit;     // load the output register
    logic err;      // emitted word is the dimension error word
    logic row_end;  // emitted word closes a product row
    logic last;     // emitted word closes the burst
  } dp_cmd_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic sum_valid;  // finished sum waits in the accumulator
    logic out_free;   // output register can take a word this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/imm_regs.sv
// ----------------------------------------------------------------------------
// imm_regs
// Dimension registers behind an APB-style port, with saturated effective sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_regs import imm_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [PADDR_W-1:0]                    paddr,
  input  wire logic [PDATA_W-1:0]                    pwdata,
  output logic      [PDATA_W-1:0]                    prdata,
  output logic                                       pready,
  output logic      [$clog2(MAX_DIM+1)-1:0]          ra_o,
  output logic      [$clog2(MAX_DIM+1)-1:0]          ca_o,
  output logic      [$clog2(MAX_DIM+1)-1:0]          rb_o,
  output logic      [$clog2(MAX_DIM+1)-1:0]          cb_o
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic             wr_en;
  reg_idx_e         reg_idx;

  // Clamp a raw size into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= CFG_W'(1);
      cols_a_q <= CFG_W'(1);
      rows_b_q <= CFG_W'(1);
      cols_b_q <= CFG_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROWS_A: rows_a_q <= pwdata[CFG_W-1:0];
        REG_COLS_A: cols_a_q <= pwdata[CFG_W-1:0];
        REG_ROWS_B: rows_b_q <= pwdata[CFG_W-1:0];
        REG_COLS_B: cols_b_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the raw value
  always_comb begin
    unique case (reg_idx)
      REG_ROWS_A: prdata = PDATA_W'(rows_a_q);
      REG_COLS_A: prdata = PDATA_W'(cols_a_q);
      REG_ROWS_B: prdata = PDATA_W'(rows_b_q);
      REG_COLS_B: prdata = PDATA_W'(cols_b_q);
      default:    prdata = '0;
    endcase
  end

  assign ra_o = eff_dim(rows_a_q);
  assign ca_o = eff_dim(cols_a_q);
  assign rb_o = eff_dim(rows_b_q);
  assign cb_o = eff_dim(cols_b_q);

endmodule

`default_nettype wire

// File: rtl/core/imm_ctrl.sv
// ----------------------------------------------------------------------------
// imm_ctrl
// Sequencer: counts the load stream, then walks row, column and inner index.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_ctrl import imm_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF,
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1),
  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int unsigned ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [DIM_W-1:0]  ra_i,
  input  wire logic [DIM_W-1:0]  ca_i,
  input  wire logic [DIM_W-1:0]  rb_i,
  input  wire logic [DIM_W-1:0]  cb_i,
  input  wire dp_stat_t          stat_i,
  output dp_cmd_t                cmd_o,
  output logic      [ADDR_W-1:0] waddr_o,
  output logic      [IDX_W-1:0]  r_o,
  output logic      [IDX_W-1:0]  c_o,
  output logic      [IDX_W-1:0]  k_o
);

  localparam int unsigned CNT_W = $clog2(2 * MAX_DIM * MAX_DIM + 1);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] load_cnt_q, load_cnt_d;
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;

  logic [CNT_W-1:0] na, nb, ntot, cnt_inc, b_off;
  logic             in_ok, in_a, in_b, load_done, dims_ok;
  logic             k_last, c_last, r_last;

  // Load position decode
  assign na        = CNT_W'(ra_i) * CNT_W'(ca_i);
  assign nb        = CNT_W'(rb_i) * CNT_W'(cb_i);
  assign ntot      = na + nb;
  assign cnt_inc   = load_cnt_q + CNT_W'(1);
  assign b_off     = load_cnt_q - na;
  assign in_ok     = in_valid_i && (state_q == ST_LOAD);
  assign in_a      = load_cnt_q < na;
  assign in_b      = !in_a && (b_off < nb);
  assign load_done = cnt_inc >= ntot;
  assign dims_ok   = (ca_i == rb_i);
  assign waddr_o   = in_a ? load_cnt_q[ADDR_W-1:0] : b_off[ADDR_W-1:0];

  // Loop ends
  assign k_last = (DIM_W'(k_q) + DIM_W'(1)) == ca_i;
  assign c_last = (DIM_W'(c_q) + DIM_W'(1)) == cb_i;
  assign r_last = (DIM_W'(r_q) + DIM_W'(1)) == ra_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_ok && load_done) begin
          state_d = dims_ok ? ST_ISSUE : ST_ERR;
        end
      end
      ST_ISSUE: begin
        if (k_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat_i.sum_valid && stat_i.out_free) begin
          state_d = (c_last && r_last) ? ST_LOAD : ST_ISSUE;
        end
      end
      ST_ERR: begin
        if (stat_i.out_free) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        cmd_o.wr_a = in_valid_i && in_a;
        cmd_o.wr_b = in_valid_i && in_b;
      end
      ST_ISSUE: begin
        cmd_o.rd    = 1'b1;
        cmd_o.first = (k_q == '0);
        cmd_o.lastk = k_last;
      end
      ST_WAIT: begin
        cmd_o.emit    = stat_i.sum_valid && stat_i.out_free;
        cmd_o.row_end = c_last;
        cmd_o.last    = c_last && r_last;
      end
      ST_ERR: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.err  = 1'b1;
        cmd_o.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Counter next values
  always_comb begin
    load_cnt_d = load_cnt_q;
    k_d        = k_q;
    c_d        = c_q;
    r_d        = r_q;
    if (in_ok) begin
      load_cnt_d = load_done ? '0 : cnt_inc;
    end
    if (state_q == ST_ISSUE) begin
      k_d = k_last ? '0 : k_q + IDX_W'(1);
    end
    if (state_q == ST_WAIT && cmd_o.emit) begin
      if (c_last) begin
        c_d = '0;
        r_d = r_last ? '0 : r_q + IDX_W'(1);
      end else begin
        c_d = c_q + IDX_W'(1);
      end
    end
  end

  // Hold state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      k_q        <= '0;
      c_q        <= '0;
      r_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      k_q        <= k_d;
      c_q        <= c_d;
      r_q        <= r_d;
    end
  end

  assign r_o = r_q;
  assign c_o = c_q;
  assign k_o = k_q;

  // Inner index is back at zero while a sum drains
  a_wait_k_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAIT |-> k_q == '0)
    else $error("inner index not cleared while draining");

  // Closing the inner loop always leads to the drain
  a_issue_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ISSUE && k_last |=> state_q == ST_WAIT)
    else $error("issue did not move to wait");

  // Never overwrite a word the consumer has not taken
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("emit while output register is blocked");

endmodule

`default_nettype wire

// File: rtl/core/imm_dp.sv
// ----------------------------------------------------------------------------
// imm_dp
// Datapath: A and B stores, multiply-accumulate pipeline, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_dp import imm_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF,
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1),
  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int unsigned ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire dp_cmd_t                  cmd_i,
  output dp_stat_t                      stat_o,
  input  wire logic        [ADDR_W-1:0] waddr_i,
  input  wire logic        [IDX_W-1:0]  r_i,
  input  wire logic        [IDX_W-1:0]  c_i,
  input  wire logic        [IDX_W-1:0]  k_i,
  input  wire logic        [DIM_W-1:0]  ca_i,
  input  wire logic        [DIM_W-1:0]  cb_i,
  input  wire logic signed [ELEM_W-1:0] element_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed      [ELEM_W-1:0] product_o,
  output logic                          row_end_o,
  output logic                          last_o,
  output logic                          dims_error_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned MUL_W = IDX_W + DIM_W;

  logic [ELEM_W-1:0] mem_a [DEPTH];
  logic [ELEM_W-1:0] mem_b [DEPTH];

  logic [MUL_W-1:0]  addr_a_w, addr_b_w;
  logic [ADDR_W-1:0] raddr_a, raddr_b;

  logic [ELEM_W-1:0] rd_a_q, rd_b_q, prod_q, acc_q;
  logic              v1_q, f1_q, l1_q, v2_q, f2_q, l2_q;
  logic              sum_valid_q;

  logic              out_valid_q;
  logic [ELEM_W-1:0] product_q;
  logic              row_end_q, last_q, err_q;
  logic              out_free;

  // Row-major read addresses
  assign addr_a_w = MUL_W'(r_i) * MUL_W'(ca_i) + MUL_W'(k_i);
  assign addr_b_w = MUL_W'(k_i) * MUL_W'(cb_i) + MUL_W'(c_i);
  assign raddr_a  = addr_a_w[ADDR_W-1:0];
  assign raddr_b  = addr_b_w[ADDR_W-1:0];

  // Store A
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      mem_a[waddr_i] <= element_i;
    end
    if (cmd_i.rd) begin
      rd_a_q <= mem_a[raddr_a];
    end
  end

  // Store B
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b) begin
      mem_b[waddr_i] <= element_i;
    end
    if (cmd_i.rd) begin
      rd_b_q <= mem_b[raddr_b];
    end
  end

  // Advance pipeline flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      f1_q <= 1'b0;
      l1_q <= 1'b0;
      v2_q <= 1'b0;
      f2_q <= 1'b0;
      l2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd;
      f1_q <= cmd_i.first;
      l1_q <= cmd_i.lastk;
      v2_q <= v1_q;
      f2_q <= f1_q;
      l2_q <= l1_q;
    end
  end

  // Multiply, then accumulate with 32-bit wrap
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= rd_a_q * rd_b_q;
    end
    if (v2_q) begin
      acc_q <= (f2_q ? '0 : acc_q) + prod_q;
    end
  end

  // Flag a finished sum until it is emitted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (v2_q && l2_q) begin
      sum_valid_q <= 1'b1;
    end else if (cmd_i.emit) begin
      sum_valid_q <= 1'b0;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      product_q <= cmd_i.err ? '0 : acc_q;
      row_end_q <= cmd_i.row_end;
      last_q    <= cmd_i.last;
      err_q     <= cmd_i.err;
    end
  end

  assign stat_o.sum_valid = sum_valid_q;
  assign stat_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign product_o    = product_q;
  assign row_end_o    = row_end_q;
  assign last_o       = last_q;
  assign dims_error_o = err_q;

  // A sum is only marked done by the closing inner step
  a_sum_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sum_valid_q) |-> $past(v2_q && l2_q))
    else $error("sum marked done without closing step");

  // A product word is only emitted from a finished sum
  a_emit_has_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !cmd_i.err |-> sum_valid_q)
    else $error("product emitted before sum finished");

endmodule

`default_nettype wire

// File: rtl/core/integer_matrix_multiply.sv
// Load: one element word per cycle; input stalls only during the output burst.
// Burst: each product word issues one A/B memory read per inner step, then passes
//   the read register, multiplier register and accumulator before it is emitted;
//   a dimension error word is emitted as soon as the output register is free.
// Reset: load count, sequencer and output valid clear; sizes return to 1.
//   The A and B stores are not cleared.
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Streams in A then B row-major and streams out their wrapped integer product.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_matrix_multiply import imm_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic        [PADDR_W-1:0] paddr,
  input  wire logic        [PDATA_W-1:0] pwdata,
  output logic             [PDATA_W-1:0] prdata,
  output logic                          pready,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [ELEM_W-1:0] element_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed      [ELEM_W-1:0] product_o,
  output logic                          row_end_o,
  output logic                          last_o,
  output logic                          dims_error_o
);

  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  logic [DIM_W-1:0]  ra, ca, rb, cb;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [ADDR_W-1:0] waddr;
  logic [IDX_W-1:0]  r_idx, c_idx, k_idx;

  // Dimension registers
  imm_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ra_o    (ra),
    .ca_o    (ca),
    .rb_o    (rb),
    .cb_o    (cb)
  );

  // Sequencer
  imm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ra_i       (ra),
    .ca_i       (ca),
    .rb_i       (rb),
    .cb_i       (cb),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .waddr_o    (waddr),
    .r_o        (r_idx),
    .c_o        (c_idx),
    .k_o        (k_idx)
  );

  // Stores and multiply-accumulate
  imm_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .waddr_i      (waddr),
    .r_i          (r_idx),
    .c_i          (c_idx),
    .k_i          (k_idx),
    .ca_i         (ca),
    .cb_i         (cb),
    .element_i    (element_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .product_o    (product_o),
    .row_end_o    (row_end_o),
    .last_o       (last_o),
    .dims_error_o (dims_error_o)
  );

endmodule

`default_nettype wire

// File: tb/tb_integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// tb_integer_matrix_multiply
// Streams matrix pairs through the multiplier and checks every product word.
// The APB port sets the sizes between loads. A class predicts the wrapped
// products and the dimension error word, and checks them in order. Both
// channels idle and stall at random, and one long output hold-off fills the
// block while more elements are offered.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_integer_matrix_multiply import imm_pkg::*;;

  localparam int unsigned MAX_DIM     = MAX_DIM_DEF;
  localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned ITEM_GOAL   = 500;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  localparam logic signed [ELEM_W-1:0] INT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic signed [ELEM_W-1:0] INT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

  // One output word
  typedef struct packed {
    logic signed [ELEM_W-1:0] product;
    logic                     row_end;
    logic                     last;
    logic                     dims_error;
  } product_word_t;

  // Predicts product words from the element stream and checks them in order
  class product_predictor;
    bit [ELEM_W-1:0] store_a [STORE_DEPTH];
    bit [ELEM_W-1:0] store_b [STORE_DEPTH];
    bit [CFG_W-1:0]  dim [4];
    int unsigned     loaded;
    int unsigned     errors;
    product_word_t   expected_products [$];

    function new();
      foreach (dim[i]) dim[i] = 1;
      loaded = 0;
      errors = 0;
    endfunction

    function void set_dim(reg_idx_e idx, bit [CFG_W-1:0] v);
      dim[int'(idx)] = v;
    endfunction

    // Clamp a size register to 1..MAX_DIM
    function int unsigned size_of(reg_idx_e idx);
      if (dim[int'(idx)] == 0) return 1;
      if (dim[int'(idx)] > MAX_DIM) return MAX_DIM;
      return int'(dim[int'(idx)]);
    endfunction

    function int unsigned load_length();
      return size_of(REG_ROWS_A) * size_of(REG_COLS_A)
           + size_of(REG_ROWS_B) * size_of(REG_COLS_B);
    endfunction

    function void take_element(bit [ELEM_W-1:0] e);
      int unsigned ra, ca, rb, cb, na, nb;
      bit [ELEM_W-1:0] acc;
      product_word_t w;
      ra = size_of(REG_ROWS_A);
      ca = size_of(REG_COLS_A);
      rb = size_of(REG_ROWS_B);
      cb = size_of(REG_COLS_B);
      na = ra * ca;
      nb = rb * cb;
      if (loaded < na) begin
        store_a[loaded] = e;
      end else if (loaded - na < nb) begin
        store_b[loaded - na] = e;
      end
      loaded++;
      if (loaded < na + nb) return;
      loaded = 0;
      // Mismatched inner sizes give a single error word
      if (ca != rb) begin
        w.product    = '0;
        w.row_end    = 1'b0;
        w.last       = 1'b1;
        w.dims_error = 1'b1;
        expected_products.push_back(w);
        return;
      end
      for (int unsigned r = 0; r < ra; r++) begin
        for (int unsigned c = 0; c < cb; c++) begin
          acc = '0;
          for (int unsigned k = 0; k < ca; k++) begin
            acc = acc + store_a[r * ca + k] * store_b[k * cb + c];
          end
          w.product    = acc;
          w.row_end    = (c == cb - 1);
          w.last       = (r == ra - 1) && (c == cb - 1);
          w.dims_error = 1'b0;
          expected_products.push_back(w);
        end
      end
    endfunction

    function void check_word(product_word_t got);
      product_word_t want;
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected word: product %0d row_end %0b last %0b dims_error %0b",
                 $time, got.product, got.row_end, got.last, got.dims_error);
        errors++;
        return;
      end
      want = expected_products.pop_front();
      if (got.product !== want.product) begin
        $display("%0t: product expected %0d got %0d", $time, want.product, got.product);
        errors++;
      end
      if (got.row_end !== want.row_end) begin
        $display("%0t: row_end expected %0b got %0b", $time, want.row_end, got.row_end);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
        errors++;
      end
      if (got.dims_error !== want.dims_error) begin
        $display("%0t: dims_error expected %0b got %0b", $time, want.dims_error,
                 got.dims_error);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [PADDR_W-1:0]       paddr       = '0;
  logic [PDATA_W-1:0]       pwdata      = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic signed [ELEM_W-1:0] element_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ELEM_W-1:0] product_o;
  logic                     row_end_o;
  logic                     last_o;
  logic                     dims_error_o;

  product_predictor pred = new();

  int unsigned              items_sent = 0;
  bit                       steady     = 1'b0;
  bit                       hold_req   = 1'b0;
  logic signed [ELEM_W-1:0] preset_elements [$];

  integer_matrix_multiply #(.MAX_DIM(MAX_DIM)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .element_i   (element_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .product_o   (product_o),
    .row_end_o   (row_end_o),
    .last_o      (last_o),
    .dims_error_o(dims_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_element();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return INT_MIN;
    if (r < 16) return INT_MAX;
    if (r < 22) return -1;
    if (r < 26) return 0;
    if (r < 50) return $signed($urandom_range(0, 200)) - 100;
    return $urandom;
  endfunction

  // Mostly small sizes, sometimes up to the limit, rarely out of range
  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return CFG_W'($urandom_range(MAX_DIM + 1, (1 << CFG_W) - 1));
    if (r < 15) return CFG_W'($urandom_range(1, MAX_DIM));
    return CFG_W'($urandom_range(1, 4));
  endfunction

  task automatic write_dim(reg_idx_e idx, logic [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= PDATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pred.set_dim(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_element(logic signed [ELEM_W-1:0] e);
    in_valid_i <= 1'b1;
    element_i  <= e;
    do @(posedge clk_i); while (in_stall_o);
    pred.take_element(e);
    items_sent++;
  endtask

  task automatic idle_input(int unsigned n);
    if (n == 0) return;
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pred.expected_products.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Set the sizes if they change, then stream whole matrix pairs
  task automatic run_matrix(logic [CFG_W-1:0] ra, logic [CFG_W-1:0] ca,
                            logic [CFG_W-1:0] rb, logic [CFG_W-1:0] cb,
                            int unsigned sets, bit pressure, bit drain);
    int unsigned n;
    if (ra != pred.dim[int'(REG_ROWS_A)] || ca != pred.dim[int'(REG_COLS_A)] ||
        rb != pred.dim[int'(REG_ROWS_B)] || cb != pred.dim[int'(REG_COLS_B)]) begin
      wait_idle();
      write_dim(REG_ROWS_A, ra);
      write_dim(REG_COLS_A, ca);
      write_dim(REG_ROWS_B, rb);
      write_dim(REG_COLS_B, cb);
    end
    for (int unsigned s = 0; s < sets; s++) begin
      n = pred.load_length();
      for (int unsigned i = 0; i < n; i++) begin
        idle_input(pick_gap());
        if (preset_elements.size() != 0) begin
          send_element(preset_elements.pop_front());
        end else begin
          send_element(pick_element());
        end
      end
      // Stall the output across the burst while the next set is offered
      if (pressure && s == 0) hold_req = 1'b1;
    end
    if (drain) wait_idle();
  endtask

  // Output side: check accepted words and stall at random
  initial begin
    int unsigned   stall_left;
    int unsigned   hold_left;
    product_word_t got;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.product    = product_o;
        got.row_end    = row_end_o;
        got.last       = last_o;
        got.dims_error = dims_error_o;
        pred.check_word(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (steady) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Give up on a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] ra, ca, rb, cb;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Wrapping products at reset sizes
    preset_elements = '{INT_MIN, -1, INT_MAX, INT_MAX};
    run_matrix(1, 1, 1, 1, 2, 1'b0, 1'b1);
    // Inner size mismatch
    preset_elements = '{0, -1, 32'h5555_5555};
    run_matrix(1, 2, 1, 1, 1, 1'b0, 1'b1);
    // Extremes through a full inner sum
    preset_elements = '{INT_MAX, INT_MIN, -1, 1, INT_MIN, INT_MAX, 2, -2};
    run_matrix(2, 2, 2, 2, 1, 1'b0, 1'b1);
    // Zero size acts as one, oversized acts as the limit
    preset_elements = '{32'hAAAA_AAAA};
    run_matrix(0, 1, 1, 15, 1, 1'b0, 1'b1);

    // Fill the block behind a long output hold-off
    run_matrix(4, 4, 4, 4, 2, 1'b1, 1'b1);
    // Largest sizes, no idling
    steady = 1'b1;
    run_matrix(CFG_W'(MAX_DIM), CFG_W'(MAX_DIM), CFG_W'(MAX_DIM), CFG_W'(MAX_DIM),
               1, 1'b0, 1'b1);
    steady = 1'b0;

    // Random sizes and contents
    while (items_sent < ITEM_GOAL) begin
      ra = pick_dim();
      ca = pick_dim();
      cb = pick_dim();
      rb = ($urandom_range(0, 99) < 20) ? pick_dim() : ca;
      steady = ($urandom_range(0, 99) < 10);
      run_matrix(ra, ca, rb, cb, $urandom_range(1, 3), 1'b0,
                 $urandom_range(0, 99) < 20);
    end
    steady = 1'b0;

    wait_idle();
    repeat (SETTLE) @(posedge clk_i);
    if (pred.expected_products.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time,
               pred.expected_products.size());
    end
    if (pred.errors == 0 && pred.expected_products.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: integer_matrix_multiply.f
rtl/core/imm_pkg.sv
rtl/core/imm_regs.sv
rtl/core/imm_ctrl.sv
rtl/core/imm_dp.sv
rtl/core/integer_matrix_multiply.sv
tb/tb_integer_matrix_multiply.sv
